@@ hdl/altc_pkg.sv @@
// Shared types, constants and functions of the assembly line token classifier.
package altc_pkg;

  localparam int LineLengthDefault = 256;
  localparam int ValueBitsDefault  = 32;
  localparam int NumKeywords       = 11;
  localparam int RegMax            = 31;

  localparam logic [7:0] CharEnd   = 8'd0;
  localparam logic [7:0] CharSpace = 8'd32;
  localparam logic [7:0] CharParen = 8'd40;
  localparam logic [7:0] CharPlus  = 8'd43;
  localparam logic [7:0] CharMinus = 8'd45;
  localparam logic [7:0] CharR     = 8'd114;

  localparam logic [3:0] KindNone     = 4'd0;
  localparam logic [3:0] KindRegister = 4'd12;
  localparam logic [3:0] KindAddress  = 4'd13;
  localparam logic [3:0] KindLiteral  = 4'd14;
  localparam logic [3:0] KindError    = 4'd15;

  localparam logic [2:0] ErrOk      = 3'd0;
  localparam logic [2:0] ErrBadReg  = 3'd1;
  localparam logic [2:0] ErrBadBase = 3'd2;
  localparam logic [2:0] ErrUnknown = 3'd3;
  localparam logic [2:0] ErrBadNum  = 3'd4;

  localparam logic [1:0] PhStart  = 2'd0;
  localparam logic [1:0] PhSign   = 2'd1;
  localparam logic [1:0] PhDigits = 2'd2;
  localparam logic [1:0] PhStop   = 2'd3;

  typedef struct packed {
    logic [1:0] phase;
    logic       neg;
    logic       ovf;
    logic       seen;
  } rdr_t;

  // Event handed from the front to the back end.
  typedef struct packed {
    logic [3:0]  kind;
    logic [2:0]  err;
    logic [31:0] v1;
    logic [31:0] v2;
    logic        done;
  } tok_t;

  function automatic int kw_len(input int k);
    case (k)
      6:        return 1;
      3, 7, 8:  return 2;
      9, 10:    return 4;
      default:  return 3;
    endcase
  endfunction

  function automatic logic [7:0] kw_char(input int k, input int p);
    logic [31:0] s;
    case (k)
      0:  s = "add";
      1:  s = "sub";
      2:  s = "and";
      3:  s = "or";
      4:  s = "slt";
      5:  s = "beq";
      6:  s = "j";
      7:  s = "lw";
      8:  s = "sw";
      9:  s = "addi";
      10: s = "subi";
      default: s = '0;
    endcase
    if (p >= kw_len(k)) return 8'd0;
    return s[8*(kw_len(k)-1-p) +: 8];
  endfunction

  function automatic logic is_dig(input logic [7:0] c);
    return c >= 8'd48 && c <= 8'd57;
  endfunction

  function automatic logic [6:0] digit_of(input logic [7:0] c);
    if (c >= 8'd48 && c <= 8'd57) return 7'(c - 8'd48);
    if (c >= 8'd97 && c <= 8'd122) return 7'(c - 8'd87);
    if (c >= 8'd65 && c <= 8'd90) return 7'(c - 8'd55);
    return 7'd99;
  endfunction

endpackage

@@ hdl/altc_front.sv @@
// Front end: per-character token state, keyword match and number readers.
module altc_front import altc_pkg::*; #(
  parameter int LINE_LENGTH = LineLengthDefault,
  parameter int VALUE_BITS  = ValueBitsDefault
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char,
  output logic       ev_valid,
  input  logic       ev_ready,
  output tok_t       ev
);

  localparam int PW = $clog2(LINE_LENGTH);
  localparam logic [PW-1:0] PosMax = PW'(LINE_LENGTH - 1);

  logic                  in_token;
  logic [PW-1:0]         pos;
  logic [7:0]            first_char;
  logic [NumKeywords-1:0] kw;
  logic [4:0]            base;
  logic                  based;
  logic [1:0]            paren;
  logic [VALUE_BITS-1:0] acc, acc2;
  rdr_t                  r1, r2;

  logic [NumKeywords-1:0] kw_next;
  logic [4:0]            base_next;
  logic                  based_next;
  logic [1:0]            paren_next;
  logic [VALUE_BITS-1:0] acc_next, acc2_next;
  rdr_t                  r1_next, r2_next;
  logic                  feed1, feed2;
  logic [4:0]            base1;
  logic                  accept, is_end, is_sep, emit;
  tok_t                  cls;

  assign in_ready = ev_ready;
  assign accept   = in_valid && in_ready;
  assign is_end   = in_char == CharEnd;
  assign is_sep   = in_char == CharSpace;
  assign emit     = accept && (is_end || (is_sep && in_token));

  // One step of a number reader; multiply by base is at most VALUE_BITS x 5 bits.
  function automatic void rd_step(input rdr_t f, input logic [VALUE_BITS-1:0] m,
                                  input logic [7:0] c, input logic [4:0] b,
                                  output rdr_t fo, output logic [VALUE_BITS-1:0] mo);
    logic [6:0]            d;
    logic [VALUE_BITS:0]   lim;
    logic [VALUE_BITS+5:0] prod;
    d  = digit_of(c);
    fo = f;
    mo = m;
    lim = (VALUE_BITS+1)'(1) << (VALUE_BITS - 1);
    if (!f.neg) lim = lim - 1'b1;
    if (f.phase == PhStop) begin
    end else if (f.phase == PhStart && c >= 8'd9 && c <= 8'd13) begin
    end else if (f.phase == PhStart && (c == CharPlus || c == CharMinus)) begin
      fo.phase = PhSign;
      fo.neg   = c == CharMinus;
    end else if ({2'b0, b} > d) begin
      prod = (VALUE_BITS+6)'(m) * (VALUE_BITS+6)'(b) + (VALUE_BITS+6)'(d);
      if (!f.ovf) begin
        if (prod > (VALUE_BITS+6)'(lim)) fo.ovf = 1'b1;
        else mo = VALUE_BITS'(prod);
      end
      fo.phase = PhDigits;
      fo.seen  = 1'b1;
    end else begin
      fo.phase = PhStop;
    end
  endfunction

  always_comb begin
    rdr_t                  t1, t2;
    logic [VALUE_BITS-1:0] m1, m2;
    kw_next    = kw;
    base_next  = base;
    based_next = based;
    paren_next = paren;
    feed1 = 1'b0;
    feed2 = 1'b0;
    base1 = 5'd10;
    for (int k = 0; k < NumKeywords; k++)
      if (32'(pos) >= kw_len(k) || kw_char(k, int'(pos)) != in_char) kw_next[k] = 1'b0;
    if (pos == '0) begin
      feed1 = is_dig(in_char);
    end else if (first_char == CharR) begin
      feed1 = 1'b1;
    end else if (is_dig(first_char)) begin
      if (pos == PW'(1)) begin
        if (is_dig(in_char)) feed1 = 1'b1;
        else begin
          based_next = 1'b1;
          case (in_char)
            8'd120: base_next = 5'd16;
            8'd100: base_next = 5'd10;
            8'd111: base_next = 5'd8;
            8'd98:  base_next = 5'd2;
            default: base_next = 5'd0;
          endcase
        end
      end else if (!based) feed1 = 1'b1;
      else if (base != 5'd0) begin
        feed1 = 1'b1;
        base1 = base;
      end
      case (paren)
        2'd0: if (in_char == CharParen) paren_next = 2'd1;
        2'd1: paren_next = 2'd2;
        default: feed2 = 1'b1;
      endcase
    end
    rd_step(r1, acc, in_char, base1, t1, m1);
    rd_step(r2, acc2, in_char, 5'd10, t2, m2);
    r1_next  = feed1 ? t1 : r1;
    acc_next = feed1 ? m1 : acc;
    if (based_next && !based) begin
      r1_next  = '0;
      acc_next = '0;
    end
    r2_next   = feed2 ? t2 : r2;
    acc2_next = feed2 ? m2 : acc2;
  end

  // Classify the finished token.
  always_comb begin
    logic                  hit;
    logic [VALUE_BITS-1:0] n1, n2;
    logic                  ok1, ok2;
    cls = '0;
    cls.done = is_end;
    hit = 1'b0;
    ok1 = r1.seen && !r1.ovf;
    ok2 = r2.seen && !r2.ovf;
    n1  = r1.neg ? VALUE_BITS'(-acc) : acc;
    n2  = r2.neg ? VALUE_BITS'(-acc2) : acc2;
    if (!in_token) begin
      cls.kind = KindNone;
    end else begin
      for (int k = NumKeywords - 1; k >= 0; k--)
        if (kw[k] && 32'(pos) == kw_len(k)) begin
          hit = 1'b1;
          cls.kind = 4'(k + 1);
        end
      if (!hit) begin
        if (first_char == CharR) begin
          if (!ok1) cls.err = ErrBadNum;
          else if (r1.neg ? acc != '0 : acc > VALUE_BITS'(RegMax)) cls.err = ErrBadReg;
          else begin
            cls.kind = KindRegister;
            cls.v1   = 32'($signed(n1));
          end
        end else if (is_dig(first_char)) begin
          if (paren != 2'd0) begin
            if (!based && !ok1) cls.err = ErrBadNum;
            else if (!ok2) cls.err = ErrBadNum;
            else begin
              cls.kind = KindAddress;
              cls.v1   = based ? 32'(first_char - 8'd48) : 32'($signed(n1));
              cls.v2   = 32'($signed(n2));
            end
          end else if (based && base == 5'd0) cls.err = ErrBadBase;
          else if (!ok1) cls.err = ErrBadNum;
          else begin
            cls.kind = KindLiteral;
            cls.v1   = 32'($signed(n1));
          end
        end else cls.err = ErrUnknown;
        if (cls.err != ErrOk) cls.kind = KindError;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ev_valid <= 1'b0;
    end else if (ev_ready) begin
      ev_valid <= emit;
    end
    if (ev_ready) ev <= cls;
    if (rst || (accept && (is_end || is_sep))) begin
      in_token   <= 1'b0;
      pos        <= '0;
      first_char <= '0;
      kw         <= '1;
      base       <= 5'd10;
      based      <= 1'b0;
      paren      <= 2'd0;
      acc        <= '0;
      acc2       <= '0;
      r1         <= '0;
      r2         <= '0;
    end else if (accept) begin
      in_token   <= 1'b1;
      if (pos < PosMax) pos <= pos + 1'b1;
      if (pos == '0) first_char <= in_char;
      kw    <= kw_next;
      base  <= base_next;
      based <= based_next;
      paren <= paren_next;
      acc   <= acc_next;
      acc2  <= acc2_next;
      r1    <= r1_next;
      r2    <= r2_next;
    end
  end

`ifndef SYNTHESIS
  a_kw_reset: assert property (@(posedge clk) disable iff (rst)
    accept && is_end |=> kw == '1 && !in_token) else $error("token state not cleared");
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    ev_valid && !ev_ready |=> ev_valid && $stable(ev)) else $error("event dropped");
  a_pos_zero: assert property (@(posedge clk) disable iff (rst)
    !in_token |-> pos == '0) else $error("position off idle");
`endif

endmodule

@@ hdl/altc_queue.sv @@
// Two-entry queue between front end and output stage.
module altc_queue import altc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr_valid,
  output logic wr_ready,
  input  tok_t wr_data,
  output logic rd_valid,
  input  logic rd_ready,
  output tok_t rd_data
);

  tok_t       mem [2];
  logic [1:0] cnt;
  logic       wp, rp;
  logic       do_wr, do_rd;

  assign wr_ready = cnt != 2'd2;
  assign rd_valid = cnt != 2'd0;
  assign rd_data  = mem[rp];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      wp  <= 1'b0;
      rp  <= 1'b0;
    end else begin
      if (do_wr) wp <= ~wp;
      if (do_rd) rp <= ~rp;
      cnt <= cnt + 2'(do_wr) - 2'(do_rd);
    end
    if (do_wr) mem[wp] <= wr_data;
  end

`ifndef SYNTHESIS
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    cnt != 2'd3) else $error("queue count out of range");
  a_ptr: assert property (@(posedge clk) disable iff (rst)
    (cnt == 2'd1) |-> (wp != rp)) else $error("pointer mismatch");
  a_flow: assert property (@(posedge clk) disable iff (rst)
    do_wr && !do_rd |=> cnt == $past(cnt) + 2'd1) else $error("count lost a write");
`endif

endmodule

@@ hdl/asm_line_token_classifier_core.sv @@
// Top level of the assembly line token classifier.
// A terminating character's result is staged in the front end, then written to the queue.
// One character per cycle unless the queue is full; digits feed a base multiply-add.
// While the output stalls, three results are held (two queued, one staged); input then waits.
// Reset: synchronous, active high; clears token state and empties the queue.
module asm_line_token_classifier_core import altc_pkg::*; #(
  parameter int LINE_LENGTH = LineLengthDefault,
  parameter int VALUE_BITS  = ValueBitsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // character
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // token_kind, error_code, first_value, second_value
  output logic        m_tlast    // line_done
);

  logic ev_valid, ev_ready;
  tok_t ev, q;

  altc_front #(.LINE_LENGTH(LINE_LENGTH), .VALUE_BITS(VALUE_BITS)) u_front (
    .clk, .rst, .in_valid(s_tvalid), .in_ready(s_tready), .in_char(s_tdata),
    .ev_valid, .ev_ready, .ev
  );

  altc_queue u_queue (
    .clk, .rst, .wr_valid(ev_valid), .wr_ready(ev_ready), .wr_data(ev),
    .rd_valid(m_tvalid), .rd_ready(m_tready), .rd_data(q)
  );

  assign m_tdata = {1'b0, q.v2, q.v1, q.err, q.kind};
  assign m_tlast = q.done;

`ifndef SYNTHESIS
  a_err_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && q.err != ErrOk |-> q.kind == KindError) else $error("error kind mismatch");
  a_none_done: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && q.kind == KindNone |-> q.done) else $error("empty result mid line");
  a_v2: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && q.kind != KindAddress |-> q.v2 == '0) else $error("stray second value");
`endif

endmodule
